>>> src/rvx_pkg.sv
package rvx_pkg;

	localparam logic [6:0] OPC_OP     = 7'b0110011;
	localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] F7_ALT     = 7'b0100000;
	localparam logic [6:0] F7_ZERO    = 7'b0000000;

	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA,
		OP_OR, OP_AND, OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_JAL, OP_JALR
	} op_t;

	// classified instruction handed from front to back
	typedef struct packed {
		op_t         op;
		logic        bad;
		logic        use_imm;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [4:0]  rd;
		logic [31:0] imm;
	} uop_t;

endpackage

>>> src/rvx_decode.sv
module rvx_decode (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [31:0]  instruction_word,
	output logic         uop_valid,
	input  logic         uop_ready,
	output rvx_pkg::uop_t uop
);
	import rvx_pkg::*;

	uop_t        dec;
	logic [31:0] w;
	logic [6:0]  f7;
	logic [2:0]  f3;
	logic [1:0]  cnt_q;
	uop_t        buf_q [2];
	logic        wr_q;
	logic        rd_q;

	assign w  = instruction_word;
	assign f7 = w[31:25];
	assign f3 = w[14:12];

	always_comb begin
		dec         = '0;
		dec.rs1     = w[19:15];
		dec.rs2     = w[24:20];
		dec.rd      = w[11:7];
		dec.imm     = {{20{w[31]}}, w[31:20]};
		dec.op      = OP_ADD;
		unique case (w[6:0])
			OPC_OP, OPC_OPIMM: begin
				dec.use_imm = (w[6:0] == OPC_OPIMM);
				case (f3)
					3'd0: begin
						if (!dec.use_imm && f7 == F7_ALT) dec.op = OP_SUB;
						else begin
							dec.op = OP_ADD;
							dec.bad = !dec.use_imm && f7 != F7_ZERO;
						end
					end
					3'd1: begin dec.op = OP_SLL; dec.bad = f7 != F7_ZERO; end
					3'd2: begin dec.op = OP_SLT; dec.bad = !dec.use_imm && f7 != F7_ZERO; end
					3'd3: begin dec.op = OP_SLTU; dec.bad = !dec.use_imm && f7 != F7_ZERO; end
					3'd4: begin dec.op = OP_XOR; dec.bad = !dec.use_imm && f7 != F7_ZERO; end
					3'd5: begin
						dec.op  = (f7 == F7_ALT) ? OP_SRA : OP_SRL;
						dec.bad = f7 != F7_ZERO && f7 != F7_ALT;
					end
					3'd6: begin dec.op = OP_OR; dec.bad = !dec.use_imm && f7 != F7_ZERO; end
					default: begin dec.op = OP_AND; dec.bad = !dec.use_imm && f7 != F7_ZERO; end
				endcase
			end
			OPC_BRANCH: begin
				dec.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
				case (f3)
					3'd0: dec.op = OP_BEQ;
					3'd1: dec.op = OP_BNE;
					3'd4: dec.op = OP_BLT;
					3'd5: dec.op = OP_BGE;
					default: dec.bad = 1'b1;
				endcase
			end
			OPC_JAL: begin
				dec.op  = OP_JAL;
				dec.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
			end
			OPC_JALR: begin
				dec.op  = OP_JALR;
				dec.bad = f3 != 3'd0;
			end
			default: dec.bad = 1'b1;
		endcase
	end

	// two-entry queue toward the execute side
	assign in_ready  = cnt_q != 2'd2;
	assign uop_valid = cnt_q != 2'd0;
	assign uop       = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (in_valid && in_ready) wr_q <= !wr_q;
			if (uop_valid && uop_ready) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, uop_valid && uop_ready};
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) buf_q[wr_q] <= dec;
	end

endmodule

>>> src/rvx_execute.sv
module rvx_execute #(
	parameter int NUM_REGS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          uop_valid,
	output logic          uop_ready,
	input  rvx_pkg::uop_t uop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   instr_pc,
	output logic [31:0]   next_pc,
	output logic [4:0]    dest_reg,
	output logic [31:0]   write_value,
	output logic          write_enable,
	output logic          branch_taken,
	output logic          unsupported
);
	import rvx_pkg::*;

	logic [31:0] regs_q [1:31];
	logic [31:0] pc_q;
	logic [31:0] a, b, bo, pc4, val, npc;
	logic        taken, writes, we, lts, fire;
	logic [4:0]  sh;

	function automatic logic [31:0] rreg(input logic [4:0] i, input logic [31:0] v);
		rreg = (i == 5'd0 || 32'(i) >= NUM_REGS) ? 32'd0 : v;
	endfunction

	assign a   = rreg(uop.rs1, regs_q[uop.rs1 == 5'd0 ? 5'd1 : uop.rs1]);
	assign b   = rreg(uop.rs2, regs_q[uop.rs2 == 5'd0 ? 5'd1 : uop.rs2]);
	assign bo  = uop.use_imm ? uop.imm : b;
	assign sh  = bo[4:0];
	assign pc4 = pc_q + 32'd4;
	assign lts = $signed(a) < $signed(bo);

	always_comb begin
		val    = 32'd0;
		taken  = 1'b0;
		writes = 1'b1;
		npc    = pc4;
		unique case (uop.op)
			OP_ADD:  val = a + bo;
			OP_SUB:  val = a - bo;
			OP_SLL:  val = a << sh;
			OP_SLT:  val = {31'd0, lts};
			OP_SLTU: val = {31'd0, a < bo};
			OP_XOR:  val = a ^ bo;
			OP_SRL:  val = a >> sh;
			OP_SRA:  val = 32'($signed(a) >>> sh);
			OP_OR:   val = a | bo;
			OP_AND:  val = a & bo;
			OP_BEQ, OP_BNE, OP_BLT, OP_BGE: begin
				writes = 1'b0;
				case (uop.op)
					OP_BEQ:  taken = a == b;
					OP_BNE:  taken = a != b;
					OP_BLT:  taken = lts;
					default: taken = !lts;
				endcase
				if (taken) npc = pc_q + uop.imm;
			end
			OP_JAL: begin
				val = pc4; taken = 1'b1; npc = pc_q + uop.imm;
			end
			default: begin
				val = pc4; taken = 1'b1; npc = (a + uop.imm) & ~32'd1;
			end
		endcase
		if (uop.bad) begin
			writes = 1'b0; taken = 1'b0; npc = pc4;
		end
		if (!writes) val = 32'd0;
		we = writes && uop.rd != 5'd0 && 32'(uop.rd) < NUM_REGS;
	end

	assign uop_ready = !out_valid || out_ready;
	assign fire      = uop_valid && uop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			pc_q      <= 32'd0;
			for (int i = 1; i < 32; i++) regs_q[i] <= 32'd0;
		end else begin
			if (uop_ready) out_valid <= uop_valid;
			if (fire) begin
				pc_q <= npc;
				if (we) regs_q[uop.rd] <= val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			instr_pc     <= pc_q;
			next_pc      <= npc;
			dest_reg     <= writes ? uop.rd : 5'd0;
			write_value  <= val;
			write_enable <= we;
			branch_taken <= taken;
			unsupported  <= uop.bad;
		end
	end

endmodule

>>> src/rv32i_alu_branch_execute.sv
// RV32I execute unit: ALU ops, BEQ/BNE/BLT/BGE, JAL, JALR on a kept regfile and pc.
// Input channel: in_valid/in_ready carry one instruction_word, fetched at the current pc.
// Output channel: out_valid/out_ready carry one result word per instruction: instr_pc,
// next_pc, dest_reg, write_value, write_enable, branch_taken, unsupported.
// A front stage decodes each word into a two-entry queue; the back stage reads the
// register file, executes and updates pc and rd, and loads the output register.
// An accepted word passes through a queue entry and then the output register.
// Throughput: one instruction per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds, the back stage stops and
// the queue fills; in_ready drops once both queue entries are in use.
// Reset clears pc and all registers to zero and empties the queue and output.
module rv32i_alu_branch_execute #(
	parameter int NUM_REGS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] instruction_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] instr_pc,
	output logic [31:0] next_pc,
	output logic [4:0]  dest_reg,
	output logic [31:0] write_value,
	output logic        write_enable,
	output logic        branch_taken,
	output logic        unsupported
);
	import rvx_pkg::*;

	uop_t uop;
	logic uop_valid, uop_ready;

	rvx_decode u_dec (
		.clk, .arst_n, .in_valid, .in_ready, .instruction_word,
		.uop_valid, .uop_ready, .uop
	);

	rvx_execute #(.NUM_REGS(NUM_REGS)) u_exe (
		.clk, .arst_n, .uop_valid, .uop_ready, .uop,
		.out_valid, .out_ready, .instr_pc, .next_pc, .dest_reg, .write_value,
		.write_enable, .branch_taken, .unsupported
	);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_pc))
		else $error("result changed while stalled");
	a_bad_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unsupported |-> !write_enable && !branch_taken &&
		next_pc == instr_pc + 32'd4)
		else $error("unsupported op had effect");
	a_we_rd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_enable |-> dest_reg != 5'd0)
		else $error("write to x0");

endmodule
